// ===== sv/dtpr_pkg.sv =====
package dtpr_pkg;

   localparam int DTPR_MAX_SIDE = 4096;

   localparam int COORD_W      = 12;
   localparam int DISP_W       = 8;
   localparam int SIDE_REG_W   = 13;
   localparam int SIDE_REG_MAX = (2 ** SIDE_REG_W) - 1;
   localparam int MARGIN_W     = 8;
   localparam int OFFSET_W     = 8;
   localparam int BASE_W       = 24;
   localparam int FOCAL_W      = 14;
   localparam int POINT_W      = 38;

   localparam int DEN_W    = DISP_W + 1;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int MAG_W    = COORD_W;
   localparam int ZLO_W    = POINT_W / 2;
   localparam int ZHI_W    = POINT_W - ZLO_W;
   localparam int PART_W   = MAG_W + ZHI_W;
   localparam int SCALED_W = MAG_W + POINT_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int REQ_DATA_W  = 2 * COORD_W + DISP_W;
   localparam int RSP_PACK_W  = 3 * POINT_W;
   localparam int RSP_DATA_W  = ((RSP_PACK_W + 7) / 8) * 8;

   localparam logic [SIDE_REG_W-1:0] RESET_WIDTH  = SIDE_REG_W'(640);
   localparam logic [SIDE_REG_W-1:0] RESET_HEIGHT = SIDE_REG_W'(480);
   localparam logic [MARGIN_W-1:0]   RESET_MARGIN = '0;
   localparam logic [OFFSET_W-1:0]   RESET_OFFSET = '0;
   localparam logic [BASE_W-1:0]     RESET_BASE   = BASE_W'(256);
   localparam logic [FOCAL_W-1:0]    RESET_FOCAL  = FOCAL_W'(500);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_WINDOW_MARGIN = 3'd2,
      CSR_DISP_OFFSET   = 3'd3,
      CSR_BASELINE      = 3'd4,
      CSR_FOCAL_LENGTH  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SIDE_REG_W-1:0] w_eff;
      logic [SIDE_REG_W-1:0] h_eff;
      logic [MARGIN_W-1:0]   margin;
      logic [OFFSET_W-1:0]   offset;
      logic [FOCAL_W-1:0]    focal;
      logic [POINT_W-1:0]    fb;
   } cfg_type;

endpackage

// ===== sv/dtpr_csr.sv =====
module dtpr_csr
   import dtpr_pkg::*;
#(
   parameter int MAX_SIDE = DTPR_MAX_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   localparam logic [SIDE_REG_W-1:0] SIDE_CAP =
      SIDE_REG_W'((MAX_SIDE > SIDE_REG_MAX) ? SIDE_REG_MAX : MAX_SIDE);

   logic [SIDE_REG_W-1:0] width_ff, width_in;
   logic [SIDE_REG_W-1:0] height_ff, height_in;
   logic [MARGIN_W-1:0]   margin_ff, margin_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [FOCAL_W-1:0]    focal_ff, focal_in;
   logic [POINT_W-1:0]    fb_ff, fb_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      margin_in = margin_ff;
      offset_in = offset_ff;
      base_in   = base_ff;
      focal_in  = focal_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:   width_in  = csr_wdata[SIDE_REG_W-1:0];
            CSR_IMAGE_HEIGHT:  height_in = csr_wdata[SIDE_REG_W-1:0];
            CSR_WINDOW_MARGIN: margin_in = csr_wdata[MARGIN_W-1:0];
            CSR_DISP_OFFSET:   offset_in = csr_wdata[OFFSET_W-1:0];
            CSR_BASELINE:      base_in   = csr_wdata[BASE_W-1:0];
            CSR_FOCAL_LENGTH:  focal_in  = csr_wdata[FOCAL_W-1:0];
            default: ;
         endcase
      end
      fb_in = POINT_W'(focal_ff) * POINT_W'(base_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         margin_ff <= RESET_MARGIN;
         offset_ff <= RESET_OFFSET;
         base_ff   <= RESET_BASE;
         focal_ff  <= RESET_FOCAL;
         fb_ff     <= POINT_W'(RESET_FOCAL) * POINT_W'(RESET_BASE);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         margin_ff <= margin_in;
         offset_ff <= offset_in;
         base_ff   <= base_in;
         focal_ff  <= focal_in;
         fb_ff     <= fb_in;
      end
   end

   always_comb begin
      cfg.w_eff  = (width_ff > SIDE_CAP) ? SIDE_CAP : width_ff;
      cfg.h_eff  = (height_ff > SIDE_CAP) ? SIDE_CAP : height_ff;
      cfg.margin = margin_ff;
      cfg.offset = offset_ff;
      cfg.focal  = focal_ff;
      cfg.fb     = fb_ff;
   end

endmodule

// ===== sv/dtpr_div.sv =====
module dtpr_div
   import dtpr_pkg::*;
#(
   parameter int DVS_W  = DEN_W,
   parameter int Q_W    = POINT_W,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  logic [Q_W-1:0]    in_num,
   input  logic [DVS_W-1:0]  in_rem,
   input  logic [DVS_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [Q_W-1:0]    out_quot,
   output logic [SIDE_W-1:0] out_side
);

   // two quotient bits per stage; Q_W is even
   localparam int STAGES = Q_W / 2;

   logic              vld_ff  [STAGES];
   logic              vld_in  [STAGES];
   logic [Q_W-1:0]    num_ff  [STAGES];
   logic [Q_W-1:0]    num_in  [STAGES];
   logic [DVS_W-1:0]  rem_ff  [STAGES];
   logic [DVS_W-1:0]  rem_in  [STAGES];
   logic [DVS_W-1:0]  den_ff  [STAGES];
   logic [DVS_W-1:0]  den_in  [STAGES];
   logic [Q_W-1:0]    quot_ff [STAGES];
   logic [Q_W-1:0]    quot_in [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];
   logic [SIDE_W-1:0] side_in [STAGES];

   logic              p_vld;
   logic [Q_W-1:0]    p_num;
   logic [DVS_W-1:0]  p_rem;
   logic [DVS_W-1:0]  p_den;
   logic [Q_W-1:0]    p_quot;
   logic [SIDE_W-1:0] p_side;
   logic [DVS_W:0]    r1;
   logic [DVS_W:0]    r2;
   logic              ge1;
   logic              ge2;
   logic [DVS_W-1:0]  mid;

   always_comb begin
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            p_vld  = in_vld;
            p_num  = in_num;
            p_rem  = in_rem;
            p_den  = in_den;
            p_quot = '0;
            p_side = in_side;
         end else begin
            p_vld  = vld_ff[s-1];
            p_num  = num_ff[s-1];
            p_rem  = rem_ff[s-1];
            p_den  = den_ff[s-1];
            p_quot = quot_ff[s-1];
            p_side = side_ff[s-1];
         end
         r1  = {p_rem, p_num[Q_W-1]};
         ge1 = (r1 >= {1'b0, p_den});
         mid = ge1 ? DVS_W'(r1 - {1'b0, p_den}) : r1[DVS_W-1:0];
         r2  = {mid, p_num[Q_W-2]};
         ge2 = (r2 >= {1'b0, p_den});
         vld_in[s]  = p_vld;
         rem_in[s]  = ge2 ? DVS_W'(r2 - {1'b0, p_den}) : r2[DVS_W-1:0];
         num_in[s]  = {p_num[Q_W-3:0], 2'b00};
         quot_in[s] = {p_quot[Q_W-3:0], ge1, ge2};
         den_in[s]  = p_den;
         side_in[s] = p_side;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < STAGES; s++) begin
            num_ff[s]  <= num_in[s];
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_in[s];
            quot_ff[s] <= quot_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_vld  = vld_ff[STAGES-1];
   assign out_quot = quot_ff[STAGES-1];
   assign out_side = side_ff[STAGES-1];

endmodule

// ===== sv/dtpr_skid.sv =====
module dtpr_skid
   import dtpr_pkg::*;
#(
   parameter int DATA_W = RSP_PACK_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [DATA_W-1:0] in_data,
   output logic              in_rdy,
   output logic              out_vld,
   output logic [DATA_W-1:0] out_data,
   input  logic              out_rdy
);

   logic              main_vld_ff, main_vld_in;
   logic [DATA_W-1:0] main_data_ff, main_data_in;
   logic              spare_vld_ff, spare_vld_in;
   logic [DATA_W-1:0] spare_data_ff, spare_data_in;

   always_comb begin
      main_vld_in   = main_vld_ff;
      main_data_in  = main_data_ff;
      spare_vld_in  = spare_vld_ff;
      spare_data_in = spare_data_ff;
      if (spare_vld_ff) begin
         if (out_rdy) begin
            main_data_in = spare_data_ff;
            spare_vld_in = 1'b0;
         end
      end else if (in_vld) begin
         if (!main_vld_ff || out_rdy) begin
            main_vld_in  = 1'b1;
            main_data_in = in_data;
         end else begin
            spare_vld_in  = 1'b1;
            spare_data_in = in_data;
         end
      end else if (out_rdy) begin
         main_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff  <= 1'b0;
         spare_vld_ff <= 1'b0;
      end else begin
         main_vld_ff  <= main_vld_in;
         spare_vld_ff <= spare_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff  <= main_data_in;
      spare_data_ff <= spare_data_in;
   end

   assign in_rdy   = !spare_vld_ff;
   assign out_vld  = main_vld_ff;
   assign out_data = main_data_ff;

endmodule

// ===== sv/disparity_to_point_reprojection.sv =====
// Stereo reprojection: each accepted pixel (row, column, disparity) gives one 3D point
// Z = focal*baseline/(disparity+offset), X = (column-w/2)*Z/focal,
// Y = (row-h/2)*Z/focal, all with 8 fraction bits and truncating division; pixels
// with zero disparity or inside the right/bottom margin give no point. One pixel is
// taken every clock while req_tready is high; a point passes through one input stage,
// a 19-stage depth divider, two scaling stages (split 12x19 multipliers and their
// sum), two parallel 19-stage lateral dividers and the output register, each divider
// resolving two quotient bits per stage. A two-entry output buffer absorbs a stall;
// req_tready falls only while both entries are full, and then the whole pipeline
// holds. Write the configuration registers only while no pixel is in flight.
module disparity_to_point_reprojection
   import dtpr_pkg::*;
#(
   parameter int MAX_SIDE = DTPR_MAX_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // row, column, disparity
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // point_x, point_y, point_z, zero pad
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   logic    adv;

   logic [COORD_W-1:0] req_row;
   logic [COORD_W-1:0] req_column;
   logic [DISP_W-1:0]  req_disparity;
   logic               keep;

   logic              a_vld_ff, a_vld_in;
   logic [DEN_W-1:0]  a_den_ff, a_den_in;
   logic [DIFF_W-1:0] a_dx_ff, a_dx_in;
   logic [DIFF_W-1:0] a_dy_ff, a_dy_in;

   logic                z_vld;
   logic [POINT_W-1:0]  z_quot;
   logic [2*DIFF_W-1:0] z_side;
   logic [DIFF_W-1:0]   dx;
   logic [DIFF_W-1:0]   dy;
   logic [MAG_W-1:0]    mag_x;
   logic [MAG_W-1:0]    mag_y;

   logic               m1_vld_ff, m1_vld_in;
   logic               m1_sx_ff, m1_sx_in;
   logic               m1_sy_ff, m1_sy_in;
   logic [POINT_W-1:0] m1_z_ff, m1_z_in;
   logic [PART_W-1:0]  m1_xlo_ff, m1_xlo_in;
   logic [PART_W-1:0]  m1_xhi_ff, m1_xhi_in;
   logic [PART_W-1:0]  m1_ylo_ff, m1_ylo_in;
   logic [PART_W-1:0]  m1_yhi_ff, m1_yhi_in;

   logic                m2_vld_ff, m2_vld_in;
   logic                m2_sx_ff, m2_sx_in;
   logic                m2_sy_ff, m2_sy_in;
   logic [POINT_W-1:0]  m2_z_ff, m2_z_in;
   logic [SCALED_W-1:0] m2_nx_ff, m2_nx_in;
   logic [SCALED_W-1:0] m2_ny_ff, m2_ny_in;

   logic               x_vld;
   logic [POINT_W-1:0] x_quot;
   logic [POINT_W:0]   x_side;
   logic               y_vld;
   logic [POINT_W-1:0] y_quot;
   logic               y_side;

   logic                  pt_vld;
   logic [POINT_W-1:0]    pt_x;
   logic [POINT_W-1:0]    pt_y;
   logic [RSP_PACK_W-1:0] pt_pack;
   logic [RSP_PACK_W-1:0] rsp_pack;

   dtpr_csr #(
      .MAX_SIDE (MAX_SIDE)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_tready    = adv;
   assign req_row       = req_tdata[COORD_W-1:0];
   assign req_column    = req_tdata[2*COORD_W-1:COORD_W];
   assign req_disparity = req_tdata[REQ_DATA_W-1:2*COORD_W];

   always_comb begin
      keep = (req_disparity != '0)
          && ((SIDE_REG_W'(req_row) + SIDE_REG_W'(cfg.margin)) < cfg.h_eff)
          && ((SIDE_REG_W'(req_column) + SIDE_REG_W'(cfg.margin)) < cfg.w_eff);
      a_vld_in = req_tvalid && keep;
      a_den_in = DEN_W'(req_disparity) + DEN_W'(cfg.offset);
      a_dx_in  = DIFF_W'(req_column) - DIFF_W'(cfg.w_eff >> 1);
      a_dy_in  = DIFF_W'(req_row) - DIFF_W'(cfg.h_eff >> 1);
   end

   dtpr_div #(
      .DVS_W  (DEN_W),
      .Q_W    (POINT_W),
      .SIDE_W (2 * DIFF_W)
   ) u_div_z (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (a_vld_ff),
      .in_num   (cfg.fb),
      .in_rem   ('0),
      .in_den   (a_den_ff),
      .in_side  ({a_dx_ff, a_dy_ff}),
      .out_vld  (z_vld),
      .out_quot (z_quot),
      .out_side (z_side)
   );

   always_comb begin
      dx        = z_side[2*DIFF_W-1:DIFF_W];
      dy        = z_side[DIFF_W-1:0];
      mag_x     = dx[DIFF_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
      mag_y     = dy[DIFF_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
      m1_vld_in = z_vld;
      m1_sx_in  = dx[DIFF_W-1];
      m1_sy_in  = dy[DIFF_W-1];
      m1_z_in   = z_quot;
      m1_xlo_in = PART_W'(mag_x) * PART_W'(z_quot[ZLO_W-1:0]);
      m1_xhi_in = PART_W'(mag_x) * PART_W'(z_quot[POINT_W-1:ZLO_W]);
      m1_ylo_in = PART_W'(mag_y) * PART_W'(z_quot[ZLO_W-1:0]);
      m1_yhi_in = PART_W'(mag_y) * PART_W'(z_quot[POINT_W-1:ZLO_W]);
   end

   always_comb begin
      m2_vld_in = m1_vld_ff;
      m2_sx_in  = m1_sx_ff;
      m2_sy_in  = m1_sy_ff;
      m2_z_in   = m1_z_ff;
      m2_nx_in  = {m1_xhi_ff, {ZLO_W{1'b0}}} + SCALED_W'(m1_xlo_ff);
      m2_ny_in  = {m1_yhi_ff, {ZLO_W{1'b0}}} + SCALED_W'(m1_ylo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff  <= 1'b0;
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff  <= a_vld_in;
         m1_vld_ff <= m1_vld_in;
         m2_vld_ff <= m2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_den_ff  <= a_den_in;
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         m1_sx_ff  <= m1_sx_in;
         m1_sy_ff  <= m1_sy_in;
         m1_z_ff   <= m1_z_in;
         m1_xlo_ff <= m1_xlo_in;
         m1_xhi_ff <= m1_xhi_in;
         m1_ylo_ff <= m1_ylo_in;
         m1_yhi_ff <= m1_yhi_in;
         m2_sx_ff  <= m2_sx_in;
         m2_sy_ff  <= m2_sy_in;
         m2_z_ff   <= m2_z_in;
         m2_nx_ff  <= m2_nx_in;
         m2_ny_ff  <= m2_ny_in;
      end
   end

   dtpr_div #(
      .DVS_W  (FOCAL_W),
      .Q_W    (POINT_W),
      .SIDE_W (POINT_W + 1)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (m2_vld_ff),
      .in_num   (m2_nx_ff[POINT_W-1:0]),
      .in_rem   (FOCAL_W'(m2_nx_ff[SCALED_W-1:POINT_W])),
      .in_den   (cfg.focal),
      .in_side  ({m2_sx_ff, m2_z_ff}),
      .out_vld  (x_vld),
      .out_quot (x_quot),
      .out_side (x_side)
   );

   dtpr_div #(
      .DVS_W  (FOCAL_W),
      .Q_W    (POINT_W),
      .SIDE_W (1)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (m2_vld_ff),
      .in_num   (m2_ny_ff[POINT_W-1:0]),
      .in_rem   (FOCAL_W'(m2_ny_ff[SCALED_W-1:POINT_W])),
      .in_den   (cfg.focal),
      .in_side  (m2_sy_ff),
      .out_vld  (y_vld),
      .out_quot (y_quot),
      .out_side (y_side)
   );

   always_comb begin
      pt_vld = x_vld && y_vld;
      if (cfg.focal == '0) begin
         pt_x = '0;
         pt_y = '0;
      end else begin
         pt_x = x_side[POINT_W] ? -x_quot : x_quot;
         pt_y = y_side ? -y_quot : y_quot;
      end
      pt_pack = {x_side[POINT_W-1:0], pt_y, pt_x};
   end

   dtpr_skid #(
      .DATA_W (RSP_PACK_W)
   ) u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (pt_vld),
      .in_data  (pt_pack),
      .in_rdy   (adv),
      .out_vld  (rsp_tvalid),
      .out_data (rsp_pack),
      .out_rdy  (rsp_tready)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_pack);

endmodule

// ===== sv/dtpr_checker.sv =====
module dtpr_checker
   import dtpr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled transfer changed or dropped");

   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   a_stall_drains: assert property (@(posedge clock) disable iff (reset)
      (!req_tready && rsp_tready) |=> req_tready)
      else $error("input stall outlived a taken transfer");

   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[3*POINT_W-1:2*POINT_W] == '0))
         |-> (rsp_tdata[2*POINT_W-1:0] == '0))
      else $error("zero depth with nonzero lateral offset");

endmodule

bind disparity_to_point_reprojection dtpr_checker u_checker (.*);
